@@ src/ctp_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the trail buffer.
package ctp_pkg;

   // Ring depth, a power of two
   localparam int RING_DEPTH = 256;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int CNT_W      = RING_AW + 1;

   localparam logic [17:0] CULL_PAD          = 18'd220;
   localparam logic [31:0] POLL_NORMAL_MS    = 32'd24;
   localparam logic [31:0] POLL_LOWLAT_MS    = 32'd32;
   localparam logic [10:0] LOWLAT_DUR_CAP    = 11'd180;
   localparam logic [15:0] LOWLAT_POINT_CAP  = 16'd24;
   localparam logic [10:0] DUR_MIN           = 11'd80;
   localparam logic [10:0] DUR_MAX           = 11'd2000;
   localparam logic [15:0] CAP_MIN           = 16'd2;
   localparam logic [15:0] CAP_MAX           = 16'd240;
   localparam logic [4:0]  DIV_STEPS         = 5'd16;

   localparam logic [2:0] MODE_MOVE  = 3'd0;
   localparam logic [2:0] MODE_TICK  = 3'd1;
   localparam logic [2:0] MODE_CLEAR = 3'd2;
   localparam logic [2:0] MODE_CULL  = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   localparam logic [1:0] CSR_DURATION = 2'd0;
   localparam logic [1:0] CSR_CAP      = 2'd1;
   localparam logic [1:0] CSR_LOWLAT   = 2'd2;

   typedef struct packed {
      logic load;
      logic move;
      logic tick_sample;
      logic clear;
      logic exp_read;
      logic exp_drop;
      logic cull_point;
      logic walk_start;
      logic walk_step;
      logic cull_cmp;
      logic entry_read;
      logic div_init;
      logic div_step;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       expired;
      logic       rect_bad;
      logic       count_zero;
      logic       idx_ok;
      logic       have_fallback;
      logic       walk_done;
      logic       div_busy;
   } status_type;

endpackage

@@ src/ctp_datapath.sv @@
// Datapath of the trail buffer: item registers, point ring, walk, cull compare and divider.
module ctp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ctp_pkg::cmd_type     cmd,
   output ctp_pkg::status_type  st,
   input  logic [2:0]           req_mode,
   input  logic signed [15:0]   req_cursor_x,
   input  logic signed [15:0]   req_cursor_y,
   input  logic                 req_poll_ok,
   input  logic [31:0]          req_now_ms,
   input  logic signed [15:0]   req_rect_left,
   input  logic signed [15:0]   req_rect_top,
   input  logic signed [15:0]   req_rect_right,
   input  logic signed [15:0]   req_rect_bottom,
   input  logic [7:0]           req_entry_index,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [10:0]          csr_write_data,
   output logic                 rsp_strobe,
   output logic                 rsp_overlaps,
   output logic [7:0]           rsp_point_count,
   output logic                 rsp_entry_valid,
   output logic signed [15:0]   rsp_entry_x,
   output logic signed [15:0]   rsp_entry_y,
   output logic [16:0]          rsp_entry_life
);

   localparam int AW = ctp_pkg::RING_AW;
   localparam int CW = ctp_pkg::CNT_W;

   // configuration
   logic [10:0] dur_ff;
   logic [7:0]  cap_ff;
   logic        lowlat_ff;

   // item registers
   logic [2:0]  mode_ff;
   logic [31:0] pos_ff;
   logic        poll_ok_ff;
   logic [31:0] now_ff;
   logic signed [17:0] rl_ff, rt_ff, rr_ff, rb_ff;
   logic [7:0]  idx_ff;

   // trail state
   logic [63:0]   ring [ctp_pkg::RING_DEPTH];
   logic [63:0]   rd_data_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   pend_pos_ff;
   logic          pend_flag_ff;
   logic [31:0]   last_pos_ff;
   logic          last_flag_ff;
   logic [31:0]   last_poll_ff;

   // walk and box
   logic [CW-1:0] walk_k_ff;
   logic          first_ff;
   logic signed [17:0] minx_ff, maxx_ff, miny_ff, maxy_ff;

   // divider
   logic [11:0] rem_ff;
   logic [4:0]  div_cnt_ff;

   // result registers
   logic        strobe_ff;
   logic        overlaps_ff;
   logic        valid_ff;
   logic [15:0] ex_ff, ey_ff;
   logic [16:0] life_ff;
   logic [7:0]  pcount_ff;

   // derived configuration
   logic [10:0] dur_c, dur_exp;
   logic [15:0] cap_c;
   always_comb begin
      dur_c = dur_ff;
      if (dur_c < ctp_pkg::DUR_MIN) dur_c = ctp_pkg::DUR_MIN;
      if (dur_c > ctp_pkg::DUR_MAX) dur_c = ctp_pkg::DUR_MAX;
      dur_exp = dur_c;
      if (lowlat_ff && dur_exp > ctp_pkg::LOWLAT_DUR_CAP) dur_exp = ctp_pkg::LOWLAT_DUR_CAP;
      cap_c = {8'd0, cap_ff};
      if (cap_c < ctp_pkg::CAP_MIN) cap_c = ctp_pkg::CAP_MIN;
      if (cap_c > ctp_pkg::CAP_MAX) cap_c = ctp_pkg::CAP_MAX;
      if (lowlat_ff && cap_c > ctp_pkg::LOWLAT_POINT_CAP) cap_c = ctp_pkg::LOWLAT_POINT_CAP;
      if (cap_c > 16'(ctp_pkg::RING_DEPTH)) cap_c = 16'(ctp_pkg::RING_DEPTH);
   end

   // tick sampling
   logic        take_pend, take_poll, have_pt, append;
   logic [31:0] pt, poll_iv;
   logic        full;
   logic [AW-1:0] h1;
   logic [CW-1:0] c1;
   always_comb begin
      poll_iv   = lowlat_ff ? ctp_pkg::POLL_LOWLAT_MS : ctp_pkg::POLL_NORMAL_MS;
      take_pend = pend_flag_ff;
      take_poll = !pend_flag_ff && poll_ok_ff &&
                  ((last_poll_ff == 32'd0) || ((now_ff - last_poll_ff) >= poll_iv));
      have_pt   = take_pend || take_poll;
      pt        = take_pend ? pend_pos_ff : pos_ff;
      append    = have_pt && !(last_flag_ff && (pt == last_pos_ff));
      full      = (count_ff == CW'(ctp_pkg::RING_DEPTH));
      h1        = full ? head_ff + AW'(1) : head_ff;
      c1        = full ? count_ff : count_ff + CW'(1);
   end

   logic [15:0] count16, idx16;
   assign count16 = 16'(count_ff);
   assign idx16   = {8'd0, idx_ff};

   // memory addressing
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   always_comb begin
      mem_we    = cmd.tick_sample && append;
      mem_waddr = head_ff + count_ff[AW-1:0];
      mem_re    = cmd.exp_read || cmd.walk_start || cmd.walk_step || cmd.entry_read;
      if (cmd.entry_read)
         mem_raddr = AW'(16'(head_ff) + idx16);
      else if (cmd.walk_step)
         mem_raddr = head_ff + walk_k_ff[AW-1:0];
      else
         mem_raddr = head_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) ring[mem_waddr] <= {now_ff, pt};
      if (mem_re) rd_data_ff <= ring[mem_raddr];
   end

   // ring pointers
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.tick_sample && append) begin
         head_in  = h1;
         count_in = c1;
         if (16'(c1) > cap_c) begin
            head_in  = h1 + AW'(1);
            count_in = c1 - CW'(1);
         end
      end else if (cmd.exp_drop) begin
         head_in  = head_ff + AW'(1);
         count_in = count_ff - CW'(1);
      end else if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end
   end

   // sample under walk
   logic signed [17:0] sx, sy;
   assign sx = 18'(signed'(rd_data_ff[15:0]));
   assign sy = 18'(signed'(rd_data_ff[31:16]));

   logic signed [17:0] fbx, fby;
   logic [31:0] fb_pos;
   assign fb_pos = last_flag_ff ? last_pos_ff : pend_pos_ff;
   assign fbx    = 18'(signed'(fb_pos[15:0]));
   assign fby    = 18'(signed'(fb_pos[31:16]));

   logic signed [17:0] bx0, bx1, by0, by1;
   logic               hit;
   always_comb begin
      bx0 = minx_ff - ctp_pkg::CULL_PAD;
      by0 = miny_ff - ctp_pkg::CULL_PAD;
      bx1 = maxx_ff + ctp_pkg::CULL_PAD + 18'sd1;
      by1 = maxy_ff + ctp_pkg::CULL_PAD + 18'sd1;
      hit = !((rr_ff <= bx0) || (bx1 <= rl_ff) || (rb_ff <= by0) || (by1 <= rt_ff));
   end

   // divider setup
   logic [31:0] age;
   logic [11:0] rem2;
   assign age  = now_ff - rd_data_ff[63:32];
   assign rem2 = {rem_ff[10:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff       <= 11'd350;
         cap_ff       <= 8'd48;
         lowlat_ff    <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_flag_ff <= 1'b0;
         pend_pos_ff  <= '0;
         last_flag_ff <= 1'b0;
         last_pos_ff  <= '0;
         last_poll_ff <= '0;
         strobe_ff    <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               ctp_pkg::CSR_DURATION: dur_ff    <= csr_write_data;
               ctp_pkg::CSR_CAP:      cap_ff    <= csr_write_data[7:0];
               ctp_pkg::CSR_LOWLAT:   lowlat_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= cmd.respond;
         if (cmd.move) begin
            pend_pos_ff  <= pos_ff;
            pend_flag_ff <= 1'b1;
         end
         if (cmd.tick_sample) begin
            if (take_pend) pend_flag_ff <= 1'b0;
            if (take_poll) last_poll_ff <= now_ff;
            if (append) begin
               last_pos_ff  <= pt;
               last_flag_ff <= 1'b1;
            end
         end
         if (cmd.clear) begin
            last_flag_ff <= 1'b0;
            last_poll_ff <= '0;
         end
         if (cmd.div_init) begin
            if (age >= 32'(dur_c) || age == 32'd0) div_cnt_ff <= '0;
            else                                   div_cnt_ff <= ctp_pkg::DIV_STEPS;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff - 5'd1;
         end
      end
   end

   // payload, walk, box, divider and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff     <= req_mode;
         pos_ff      <= {req_cursor_y, req_cursor_x};
         poll_ok_ff  <= req_poll_ok;
         now_ff      <= req_now_ms;
         rl_ff       <= 18'(req_rect_left);
         rt_ff       <= 18'(req_rect_top);
         rr_ff       <= 18'(req_rect_right);
         rb_ff       <= 18'(req_rect_bottom);
         idx_ff      <= req_entry_index;
         overlaps_ff <= 1'b0;
         valid_ff    <= 1'b0;
         ex_ff       <= '0;
         ey_ff       <= '0;
         life_ff     <= '0;
      end
      if (cmd.cull_point) begin
         minx_ff <= fbx;
         maxx_ff <= fbx;
         miny_ff <= fby;
         maxy_ff <= fby;
      end
      if (cmd.walk_start) begin
         walk_k_ff <= CW'(1);
         first_ff  <= 1'b1;
      end
      if (cmd.walk_step) begin
         first_ff <= 1'b0;
         if (!st.walk_done) walk_k_ff <= walk_k_ff + CW'(1);
         if (first_ff || sx < minx_ff) minx_ff <= sx;
         if (first_ff || sx > maxx_ff) maxx_ff <= sx;
         if (first_ff || sy < miny_ff) miny_ff <= sy;
         if (first_ff || sy > maxy_ff) maxy_ff <= sy;
      end
      if (cmd.cull_cmp) overlaps_ff <= hit;
      if (cmd.div_init) begin
         valid_ff <= 1'b1;
         ex_ff    <= rd_data_ff[15:0];
         ey_ff    <= rd_data_ff[31:16];
         rem_ff   <= 12'(dur_c) - 12'(age[10:0]);
         if (age >= 32'(dur_c)) life_ff <= '0;
         else if (age == 32'd0) life_ff <= 17'h10000;
         else                   life_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem2 >= 12'(dur_c)) begin
            rem_ff  <= rem2 - 12'(dur_c);
            life_ff <= {life_ff[15:0], 1'b1};
         end else begin
            rem_ff  <= rem2;
            life_ff <= {life_ff[15:0], 1'b0};
         end
      end
      if (cmd.respond) pcount_ff <= count16[7:0];
   end

   always_comb begin
      st.mode          = mode_ff;
      st.expired       = (now_ff - rd_data_ff[63:32]) > 32'(dur_exp);
      st.rect_bad      = (rl_ff >= rr_ff) || (rt_ff >= rb_ff);
      st.count_zero    = (count_ff == '0);
      st.idx_ok        = idx16 < count16;
      st.have_fallback = last_flag_ff || pend_flag_ff;
      st.walk_done     = (walk_k_ff == count_ff);
      st.div_busy      = (div_cnt_ff != '0);
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_overlaps    = overlaps_ff;
   assign rsp_point_count = pcount_ff;
   assign rsp_entry_valid = valid_ff;
   assign rsp_entry_x     = ex_ff;
   assign rsp_entry_y     = ey_ff;
   assign rsp_entry_life  = life_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      16'(count_ff) <= 16'(ctp_pkg::RING_DEPTH))
      else $error("point count beyond ring depth");
   a_strobe_after_respond: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> strobe_ff)
      else $error("respond without strobe");
   a_div_step_live: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> div_cnt_ff != '0)
      else $error("divider stepped while idle");

endmodule

@@ src/ctp_control.sv @@
// Controller state machine of the trail buffer.
module ctp_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ctp_pkg::status_type st,
   output ctp_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_EXP_RD   = 4'd2;
   localparam logic [3:0] S_EXP_CHK  = 4'd3;
   localparam logic [3:0] S_WALK     = 4'd4;
   localparam logic [3:0] S_CMP      = 4'd5;
   localparam logic [3:0] S_RD_WAIT  = 4'd6;
   localparam logic [3:0] S_DIV      = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            case (st.mode)
               ctp_pkg::MODE_MOVE:  cmd.move = 1'b1;
               ctp_pkg::MODE_TICK: begin
                  cmd.tick_sample = 1'b1;
                  state_in        = S_EXP_RD;
               end
               ctp_pkg::MODE_CLEAR: cmd.clear = 1'b1;
               ctp_pkg::MODE_CULL: begin
                  if (!st.rect_bad) begin
                     if (!st.count_zero) begin
                        cmd.walk_start = 1'b1;
                        state_in       = S_WALK;
                     end else if (st.have_fallback) begin
                        cmd.cull_point = 1'b1;
                        state_in       = S_CMP;
                     end
                  end
               end
               ctp_pkg::MODE_READ: begin
                  if (st.idx_ok) begin
                     cmd.entry_read = 1'b1;
                     state_in       = S_RD_WAIT;
                  end
               end
               default: ;
            endcase
         end
         S_EXP_RD: begin
            if (st.count_zero) state_in = S_RESP;
            else begin
               cmd.exp_read = 1'b1;
               state_in     = S_EXP_CHK;
            end
         end
         S_EXP_CHK: begin
            if (st.expired) begin
               cmd.exp_drop = 1'b1;
               state_in     = S_EXP_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (st.walk_done) state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cull_cmp = 1'b1;
            state_in     = S_RESP;
         end
         S_RD_WAIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (st.div_busy) cmd.div_step = 1'b1;
            else             state_in     = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

   a_load_then_dispatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == S_DISPATCH)
      else $error("accepted item not dispatched");
   a_respond_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("no return to idle after response");
   a_one_ring_op: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.tick_sample, cmd.exp_drop, cmd.clear}) <= 1)
      else $error("conflicting ring pointer updates");

endmodule

@@ src/cursor_trail_point_buffer_top.sv @@
// Top level of the cursor trail point buffer: controller plus datapath.
//
// Command-style block: an item is taken when start is high and busy is low, and
// its single result appears one cycle on the rsp_ ports, marked by rsp_strobe;
// the receiver cannot stall, so results must be captured on that cycle. Items are
// handled one at a time, busy stays high until the result is issued. Move, clear
// and unknown modes respond after dispatch; tick samples, then reads and drops
// expired points from the oldest end through the one-read ring memory; cull
// query walks the stored points, one stored point read per cycle; read entry runs
// the 16-step radix-2 divider that forms the Q16 fade life. Configuration writes
// on the csr_ port take effect at once and belong in idle time. The 256-entry ring
// needs no clearing pass after reset; only entries below the point count are used.
module cursor_trail_point_buffer_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_mode,
   input  logic signed [15:0]  req_cursor_x,
   input  logic signed [15:0]  req_cursor_y,
   input  logic                req_poll_ok,
   input  logic [31:0]         req_now_ms,
   input  logic signed [15:0]  req_rect_left,
   input  logic signed [15:0]  req_rect_top,
   input  logic signed [15:0]  req_rect_right,
   input  logic signed [15:0]  req_rect_bottom,
   input  logic [7:0]          req_entry_index,
   output logic                rsp_strobe,
   output logic                rsp_overlaps,
   output logic [7:0]          rsp_point_count,
   output logic                rsp_entry_valid,
   output logic signed [15:0]  rsp_entry_x,
   output logic signed [15:0]  rsp_entry_y,
   output logic [16:0]         rsp_entry_life,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [10:0]         csr_write_data
);

   ctp_pkg::cmd_type    cmd;
   ctp_pkg::status_type st;

   // sequencing: dispatch, expiry loop, cull walk, divider
   ctp_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   // ring memory, trail state, config and result registers
   ctp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_mode         (req_mode),
      .req_cursor_x     (req_cursor_x),
      .req_cursor_y     (req_cursor_y),
      .req_poll_ok      (req_poll_ok),
      .req_now_ms       (req_now_ms),
      .req_rect_left    (req_rect_left),
      .req_rect_top     (req_rect_top),
      .req_rect_right   (req_rect_right),
      .req_rect_bottom  (req_rect_bottom),
      .req_entry_index  (req_entry_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_overlaps     (rsp_overlaps),
      .rsp_point_count  (rsp_point_count),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_entry_x      (rsp_entry_x),
      .rsp_entry_y      (rsp_entry_y),
      .rsp_entry_life   (rsp_entry_life)
   );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the cursor trail point buffer top level.
`timescale 1ns / 100ps

module tb;

   // One input item as driven on the req_ ports
   typedef struct {
      logic [2:0]         mode;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               poll_ok;
      logic [31:0]        now_ms;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
      logic [7:0]         index;
   } trail_item_type;

   // One result as seen on the rsp_ ports
   typedef struct {
      logic        overlaps;
      logic [7:0]  point_count;
      logic        entry_valid;
      logic [15:0] entry_x;
      logic [15:0] entry_y;
      logic [16:0] entry_life;
   } trail_result_type;

   // Mirror of the trail state; predicts one result per accepted item
   class trail_scoreboard;
      bit [63:0]        ring [ctp_pkg::RING_DEPTH];
      int unsigned      head, count;
      bit [31:0]        pend_pos, last_pos, last_poll;
      bit               pend_flag, last_flag;
      bit [10:0]        duration = 11'd350;
      bit [7:0]         cap = 8'd48;
      bit               lowlat = 1'b0;
      trail_result_type expected_q [$];
      int               errors = 0;

      function void write_reg(logic [1:0] idx, logic [10:0] value);
         case (idx)
            ctp_pkg::CSR_DURATION: duration = value;
            ctp_pkg::CSR_CAP:      cap = value[7:0];
            ctp_pkg::CSR_LOWLAT:   lowlat = value[0];
            default: ;
         endcase
      endfunction

      function int unsigned dur_clamped();
         int unsigned d;
         d = duration;
         if (d < 80) d = 80;
         if (d > 2000) d = 2000;
         return d;
      endfunction

      function void drop_oldest();
         if (count != 0) begin
            head = (head + 1) % ctp_pkg::RING_DEPTH;
            count--;
         end
      endfunction

      function void sample_tick(bit [31:0] pos, bit poll_ok, bit [31:0] now);
         bit          have;
         bit [31:0]   pt;
         int unsigned c, d;
         have = 0;
         pt = '0;
         if (pend_flag) begin
            pt = pend_pos;
            pend_flag = 0;
            have = 1;
         end else if ((last_poll == 0 ||
                      (now - last_poll) >= (lowlat ? ctp_pkg::POLL_LOWLAT_MS
                                                   : ctp_pkg::POLL_NORMAL_MS))
                      && poll_ok) begin
            pt = pos;
            have = 1;
            last_poll = now;
         end
         if (have && !(last_flag && pt == last_pos)) begin
            if (count >= ctp_pkg::RING_DEPTH) drop_oldest();
            ring[(head + count) % ctp_pkg::RING_DEPTH] = {now, pt};
            count++;
            c = cap;
            if (c < 2) c = 2;
            if (c > 240) c = 240;
            if (lowlat && c > 24) c = 24;
            if (count > c) drop_oldest();
            last_pos = pt;
            last_flag = 1;
         end
         d = dur_clamped();
         if (lowlat && d > 180) d = 180;
         // expire from the oldest end
         while (count > 0 && (now - ring[head][63:32]) > d) drop_oldest();
      endfunction

      function bit cull_hit(trail_item_type it);
         int        minx, miny, maxx, maxy, x, y;
         bit [31:0] p;
         if (it.left >= it.right || it.top >= it.bottom) return 0;
         if (count > 0) begin
            p = ring[head][31:0];
            minx = $signed(p[15:0]);
            maxx = minx;
            miny = $signed(p[31:16]);
            maxy = miny;
            for (int k = 1; k < count; k++) begin
               p = ring[(head + k) % ctp_pkg::RING_DEPTH][31:0];
               x = $signed(p[15:0]);
               y = $signed(p[31:16]);
               if (x < minx) minx = x;
               if (y < miny) miny = y;
               if (x > maxx) maxx = x;
               if (y > maxy) maxy = y;
            end
         end else if (last_flag || pend_flag) begin
            p = last_flag ? last_pos : pend_pos;
            minx = $signed(p[15:0]);
            maxx = minx;
            miny = $signed(p[31:16]);
            maxy = miny;
         end else begin
            return 0;
         end
         minx -= 220;
         miny -= 220;
         maxx += 221;
         maxy += 221;
         return !(it.right <= minx || maxx <= it.left || it.bottom <= miny || maxy <= it.top);
      endfunction

      function void note_item(trail_item_type it);
         trail_result_type r;
         bit [63:0]        e;
         bit [31:0]        age;
         int unsigned      d;
         longint           life;
         r = '{default: '0};
         case (it.mode)
            ctp_pkg::MODE_MOVE: begin
               pend_pos = {it.y, it.x};
               pend_flag = 1;
            end
            ctp_pkg::MODE_TICK:  sample_tick({it.y, it.x}, it.poll_ok, it.now_ms);
            ctp_pkg::MODE_CLEAR: begin
               count = 0;
               head = 0;
               last_flag = 0;
               last_poll = 0;
            end
            ctp_pkg::MODE_CULL:  r.overlaps = cull_hit(it);
            ctp_pkg::MODE_READ: begin
               if (it.index < count) begin
                  e = ring[(head + it.index) % ctp_pkg::RING_DEPTH];
                  age = it.now_ms - e[63:32];
                  d = dur_clamped();
                  life = 0;
                  if (age < d) life = ((longint'(d - age)) << 16) / d;
                  r.entry_valid = 1;
                  r.entry_x = e[15:0];
                  r.entry_y = e[31:16];
                  r.entry_life = life[16:0];
               end
            end
            default: ;
         endcase
         r.point_count = count[7:0];
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void field_cmp(string name, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(trail_result_type a);
         trail_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none actual count %0d",
                     $time, a.point_count);
            return;
         end
         e = expected_q[0];
         expected_q.delete(0);
         field_cmp("overlaps", e.overlaps, a.overlaps);
         field_cmp("point_count", e.point_count, a.point_count);
         field_cmp("entry_valid", e.entry_valid, a.entry_valid);
         field_cmp("entry_x", $signed(e.entry_x), $signed(a.entry_x));
         field_cmp("entry_y", $signed(e.entry_y), $signed(a.entry_y));
         field_cmp("entry_life", e.entry_life, a.entry_life);
      endfunction
   endclass

   logic               clock, reset, start, busy;
   logic [2:0]         req_mode;
   logic signed [15:0] req_cursor_x, req_cursor_y;
   logic               req_poll_ok;
   logic [31:0]        req_now_ms;
   logic signed [15:0] req_rect_left, req_rect_top, req_rect_right, req_rect_bottom;
   logic [7:0]         req_entry_index;
   logic               rsp_strobe, rsp_overlaps, rsp_entry_valid;
   logic [7:0]         rsp_point_count;
   logic signed [15:0] rsp_entry_x, rsp_entry_y;
   logic [16:0]        rsp_entry_life;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [10:0]        csr_write_data;

   cursor_trail_point_buffer_top u_top (.*);

   trail_scoreboard sb = new();
   bit              gaps_on = 1;    // sender idling enabled
   bit [31:0]       clk_ms = 0;     // running time stamp for random items
   int              quiet_cycles = 0;

   localparam int WATCHDOG_LIMIT = 20000;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Monitor: check results and note accepted items on the same edge samples
   always @(posedge clock) begin
      trail_item_type   it;
      trail_result_type r;
      if (!reset) begin
         if (rsp_strobe) begin
            r = '{rsp_overlaps, rsp_point_count, rsp_entry_valid,
                  rsp_entry_x, rsp_entry_y, rsp_entry_life};
            sb.check_result(r);
         end
         if (start && !busy) begin
            it = '{req_mode, req_cursor_x, req_cursor_y, req_poll_ok, req_now_ms,
                   req_rect_left, req_rect_top, req_rect_right, req_rect_bottom,
                   req_entry_index};
            sb.note_item(it);
         end
         // watchdog: any handshake resets it
         if (rsp_strobe || (start && !busy)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Present one item and hold it until the block takes it
   task automatic send_item(trail_item_type it);
      if (gaps_on && $urandom_range(99) < 17) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start           <= 1;
      req_mode        <= it.mode;
      req_cursor_x    <= it.x;
      req_cursor_y    <= it.y;
      req_poll_ok     <= it.poll_ok;
      req_now_ms      <= it.now_ms;
      req_rect_left   <= it.left;
      req_rect_top    <= it.top;
      req_rect_right  <= it.right;
      req_rect_bottom <= it.bottom;
      req_entry_index <= it.index;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold off until every expected result is in, then let the block settle
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [10:0] value);
      csr_write_enable <= 1;
      csr_index        <= idx;
      csr_write_data   <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic trail_item_type make_item(logic [2:0] mode, int x, int y, bit poll,
                                                bit [31:0] now);
      trail_item_type it;
      it = '{mode: mode, x: 16'(x), y: 16'(y), poll_ok: poll, now_ms: now,
             left: -16'sd100, top: -16'sd100, right: 16'sd100, bottom: 16'sd100,
             index: 8'd0};
      return it;
   endfunction

   function automatic logic signed [15:0] rand_coord();
      // mostly clustered so trails overlap query boxes, sometimes full range
      if ($urandom_range(99) < 70) return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      return 16'($urandom);
   endfunction

   function automatic trail_item_type rand_item();
      trail_item_type it;
      int             sel, w, h;
      sel = $urandom_range(99);
      // time mostly creeps forward; rare jumps exercise wrap and high bits
      if ($urandom_range(99) < 3) clk_ms = $urandom;
      else clk_ms += $urandom_range(0, 30);
      it.now_ms  = clk_ms;
      it.x       = rand_coord();
      it.y       = rand_coord();
      it.poll_ok = $urandom_range(99) < 75;
      if (sel < 25)      it.mode = ctp_pkg::MODE_MOVE;
      else if (sel < 60) it.mode = ctp_pkg::MODE_TICK;
      else if (sel < 76) it.mode = ctp_pkg::MODE_CULL;
      else if (sel < 94) it.mode = ctp_pkg::MODE_READ;
      else if (sel < 97) it.mode = ctp_pkg::MODE_CLEAR;
      else               it.mode = ctp_pkg::MODE_READ + 3'($urandom_range(1, 3));
      if ($urandom_range(99) < 80) begin
         w = $urandom_range(0, 3000);
         h = $urandom_range(0, 3000);
         it.left   = rand_coord();
         it.top    = rand_coord();
         it.right  = it.left + 16'(w);
         it.bottom = it.top + 16'(h);
      end else begin
         it.left   = 16'($urandom);
         it.top    = 16'($urandom);
         it.right  = 16'($urandom);
         it.bottom = 16'($urandom);
      end
      if ($urandom_range(99) < 85) it.index = 8'($urandom_range(0, sb.count + 2));
      else it.index = 8'($urandom);
      return it;
   endfunction

   // Per-phase settings: duration, cap, low-latency
   int unsigned phase_dur [8] = '{350, 80, 2000, 0, 2047, 500, 120, 1000};
   int unsigned phase_cap [8] = '{48, 2, 240, 0, 255, 1, 30, 5};
   bit          phase_ll  [8] = '{0, 0, 0, 1, 1, 0, 1, 0};

   initial begin
      trail_item_type it;
      reset = 1;
      start = 0;
      req_mode = ctp_pkg::MODE_MOVE;
      req_cursor_x = 0;
      req_cursor_y = 0;
      req_poll_ok = 0;
      req_now_ms = 0;
      req_rect_left = 0;
      req_rect_top = 0;
      req_rect_right = 0;
      req_rect_bottom = 0;
      req_entry_index = 0;
      csr_write_enable = 0;
      csr_index = ctp_pkg::CSR_DURATION;
      csr_write_data = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at reset settings
      it = make_item(ctp_pkg::MODE_READ, 0, 0, 0, 0);            // read while empty
      send_item(it);
      it = make_item(ctp_pkg::MODE_CULL, 0, 0, 0, 0);            // no points, no fallback
      send_item(it);
      it = make_item(ctp_pkg::MODE_MOVE, 32767, -32768, 0, 0);
      send_item(it);
      it = make_item(ctp_pkg::MODE_CULL, 0, 0, 0, 0);            // box from pending position
      it.left = 32000; it.right = 32767; it.top = -32768; it.bottom = -32000;
      send_item(it);
      it = make_item(ctp_pkg::MODE_TICK, 0, 0, 0, 0);            // takes pending move
      send_item(it);
      it = make_item(ctp_pkg::MODE_TICK, -32768, 32767, 1, 5);   // poll at first poll time
      send_item(it);
      it = make_item(ctp_pkg::MODE_TICK, 100, 100, 1, 10);       // poll interval not elapsed
      send_item(it);
      it = make_item(ctp_pkg::MODE_TICK, -32768, 32767, 1, 40);  // same as last sample
      send_item(it);
      it = make_item(ctp_pkg::MODE_READ, 0, 0, 0, 100);
      send_item(it);
      it.index = 1; send_item(it);
      it.index = 8'd255; send_item(it);                          // out of range
      it = make_item(ctp_pkg::MODE_CULL, 0, 0, 0, 100);          // inverted rectangle
      it.left = 10; it.right = -10;
      send_item(it);
      it = make_item(ctp_pkg::MODE_CULL, 0, 0, 0, 100);          // whole plane
      it.left = -32768; it.top = -32768; it.right = 32767; it.bottom = 32767;
      send_item(it);
      for (int m = 1; m <= 3; m++) begin                         // unknown modes
         it = make_item(ctp_pkg::MODE_READ + 3'(m), 0, 0, 1, 100);
         send_item(it);
      end
      it = make_item(ctp_pkg::MODE_CLEAR, 0, 0, 0, 100);
      send_item(it);
      it = make_item(ctp_pkg::MODE_CULL, 0, 0, 0, 100);          // empty after clear
      send_item(it);
      it = make_item(ctp_pkg::MODE_TICK, 7, -7, 1, 32'hFFFF_FFF0);
      send_item(it);
      it = make_item(ctp_pkg::MODE_TICK, 9, -9, 1, 32'd20);      // across the time wrap
      send_item(it);
      it = make_item(ctp_pkg::MODE_READ, 0, 0, 0, 32'd30);
      send_item(it);
      it = make_item(ctp_pkg::MODE_TICK, 9, -9, 0, 32'd1000);    // expires everything
      send_item(it);
      clk_ms = 1000;

      // Random phases, configuration changed only while idle
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         csr_write(ctp_pkg::CSR_DURATION, 11'(phase_dur[ph]));
         csr_write(ctp_pkg::CSR_CAP, 11'(phase_cap[ph]));
         csr_write(ctp_pkg::CSR_LOWLAT, 11'(phase_ll[ph]));
         gaps_on = (ph != 3);
         for (int n = 0; n < 225; n++) begin
            it = rand_item();
            send_item(it);
         end
      end

      start <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/ctp_pkg.sv
src/ctp_datapath.sv
src/ctp_control.sv
src/cursor_trail_point_buffer_top.sv
dv/tb.sv
